// ===== hdl/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// Shared constants and types of the Sobel edge detector: field widths,
// gray weights, register indexes and the structures passed between stages.
// ----------------------------------------------------------------------------
package sed_pkg;

   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 10;
   localparam int CFG_W_W    = 11;
   localparam int CFG_H_W    = 13;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int WEIGHT_W   = 16;
   localparam int GRAY_ACC_W = PIX_W + WEIGHT_W;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_HEIGHT        = 4096;
   localparam int MIN_SIZE          = 3;

   localparam logic [CFG_W_W-1:0] RESET_WIDTH  = CFG_W_W'(640);
   localparam logic [CFG_H_W-1:0] RESET_HEIGHT = CFG_H_W'(480);

   // Gray weights in unsigned 0.16 fixed point.
   localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = WEIGHT_W'(7471);
   localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = WEIGHT_W'(38470);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = WEIGHT_W'(19595);

   localparam logic [PIX_W-1:0] EDGE_MAX = PIX_W'(255);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Position of one pixel and the flags of the results it causes.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [COL_W-1:0] last_column;
      logic             row_nonzero;
      logic             col_nonzero;
      logic             last_col;
      logic             last_row;
      logic             border;
      logic             frame_last_above;
      logic             frame_last_edge;
      logic             frame_last_here;
   } meta_type;

   typedef struct packed {
      logic     valid;
      meta_type meta;
   } stage_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [PIX_W-1:0] value;
      logic             last;
   } result_type;

   // Index 3*k + j: row k of the window (0 is the oldest line), column j
   // (2 is the newest pixel).
   typedef logic [8:0][PIX_W-1:0] window_type;

endpackage

// ===== hdl/sed_ram.sv =====
// ----------------------------------------------------------------------------
// sed_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module sed_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sed_window.sv =====
// ----------------------------------------------------------------------------
// sed_window
// Pixel position counters, gray conversion, the two gray line stores and the
// 3x3 window. Stage 1 holds the weighted products and the line store read;
// the line stores are written back and the window shifts as the word leaves
// stage 1.
// ----------------------------------------------------------------------------
module sed_window #(
   parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         pixel_valid,
   input  logic [sed_pkg::PIX_W-1:0]    blue,
   input  logic [sed_pkg::PIX_W-1:0]    green,
   input  logic [sed_pkg::PIX_W-1:0]    red,
   input  logic [sed_pkg::CFG_W_W-1:0]  frame_width,
   input  logic [sed_pkg::CFG_H_W-1:0]  frame_height,
   output sed_pkg::stage_type           win_stage,
   output sed_pkg::window_type          window
);

   import sed_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   meta_type              meta_in;
   logic [AW-1:0]         idx_in;
   logic [CFG_W_W-1:0]    col_ext;
   logic [CFG_H_W-1:0]    row_ext;

   logic                  s1_valid_ff, s1_valid_in;
   meta_type              s1_meta_ff;
   logic [AW-1:0]         s1_idx_ff;
   logic [GRAY_ACC_W-1:0] prod_blue_ff, prod_green_ff, prod_red_ff;

   logic                  s2_valid_ff, s2_valid_in;
   meta_type              s2_meta_ff;
   window_type            window_ff, window_in;

   logic [GRAY_ACC_W-1:0] gray_acc;
   logic [PIX_W-1:0]      gray;
   logic [PIX_W-1:0]      upper_rd, middle_rd;
   logic                  ram_wr_en;
   logic                  s1_leave;

   // Position flags of the incoming pixel and of the results it causes.
   always_comb begin
      col_ext = CFG_W_W'(col_ff);
      row_ext = CFG_H_W'(row_ff);

      meta_in.row              = row_ff;
      meta_in.column           = col_ff;
      meta_in.last_column      = COL_W'(frame_width - CFG_W_W'(1));
      meta_in.row_nonzero      = (row_ff != '0);
      meta_in.col_nonzero      = (col_ff != '0);
      meta_in.last_col         = ((col_ext + CFG_W_W'(1)) >= frame_width);
      meta_in.last_row         = ((row_ext + CFG_H_W'(1)) >= frame_height);
      // The window result sits one row up and one column left.
      meta_in.border           = (row_ff == ROW_W'(1)) || (col_ff == COL_W'(1)) ||
                                 (row_ext >= frame_height) || (col_ext >= frame_width);
      meta_in.frame_last_edge  = (row_ext == frame_height) && (col_ext == frame_width);
      meta_in.frame_last_above = (row_ext == frame_height);
      meta_in.frame_last_here  = ((row_ext + CFG_H_W'(1)) == frame_height) &&
                                 ((col_ext + CFG_W_W'(1)) == frame_width);

      idx_in = (32'(col_ff) < MAX_WIDTH) ? AW'(col_ff) : AW'(MAX_WIDTH - 1);

      row_in = row_ff;
      col_in = col_ff;
      if (pixel_valid) begin
         if (meta_in.last_col) begin
            col_in = '0;
            row_in = meta_in.last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Stage 1: weighted components and the line store read.
   assign s1_valid_in = advance ? pixel_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_valid) begin
         s1_meta_ff    <= meta_in;
         s1_idx_ff     <= idx_in;
         prod_blue_ff  <= GRAY_ACC_W'(blue)  * GRAY_ACC_W'(WEIGHT_BLUE);
         prod_green_ff <= GRAY_ACC_W'(green) * GRAY_ACC_W'(WEIGHT_GREEN);
         prod_red_ff   <= GRAY_ACC_W'(red)   * GRAY_ACC_W'(WEIGHT_RED);
      end
   end

   // The weights add up to one, so the sum never overflows the accumulator.
   assign gray_acc  = prod_blue_ff + prod_green_ff + prod_red_ff;
   assign gray      = gray_acc[GRAY_ACC_W-1 -: PIX_W];
   assign s1_leave  = advance && s1_valid_ff;
   assign ram_wr_en = s1_leave;

   // The read data stays put while stage 1 stalls, since reads only happen
   // when a new word enters.
   sed_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_upper (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (middle_rd),
      .rd_en   (pixel_valid),
      .rd_addr (idx_in),
      .rd_data (upper_rd)
   );

   sed_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_middle (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (gray),
      .rd_en   (pixel_valid),
      .rd_addr (idx_in),
      .rd_data (middle_rd)
   );

   // Stage 2: the window itself is the stage register.
   always_comb begin
      window_in    = window_ff;
      window_in[0] = window_ff[1];
      window_in[1] = window_ff[2];
      window_in[2] = upper_rd;
      window_in[3] = window_ff[4];
      window_in[4] = window_ff[5];
      window_in[5] = middle_rd;
      window_in[6] = window_ff[7];
      window_in[7] = window_ff[8];
      window_in[8] = gray;
   end

   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (s1_leave) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_leave) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   assign win_stage.valid = s2_valid_ff;
   assign win_stage.meta  = s2_meta_ff;
   assign window          = window_ff;

endmodule

// ===== hdl/sed_result.sv =====
// ----------------------------------------------------------------------------
// sed_result
// Sobel kernels on the window, the per-pixel bundle of up to three results,
// and the output register with a skid word that hands them out one by one.
// ----------------------------------------------------------------------------
module sed_result (
   input  logic                             clock,
   input  logic                             reset,
   input  sed_pkg::stage_type               win_stage,
   input  sed_pkg::window_type              window,
   output logic                             advance,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: out_row [11:0], out_column [21:12], edge_value [29:22], zeros
   output logic [sed_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);

   import sed_pkg::*;

   logic [9:0]       gx_pos, gx_neg, gy_pos, gy_neg;
   logic [9:0]       gx_abs, gy_abs;
   logic [10:0]      magnitude;
   logic [PIX_W-1:0] edge_value;

   result_type       slot_in [3];
   logic [2:0]       bundle_mask;

   logic [2:0]       mask_ff, mask_in;
   result_type       slot_ff [3];
   logic             pending, pop, last_one, em_free;
   result_type       pick;

   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;
   logic             skid_valid_ff, skid_valid_in;
   result_type       skid_ff, skid_in;

   // Sobel X and Y, L1 magnitude, saturated.
   always_comb begin
      gx_pos = 10'(window[2]) + {1'b0, window[5], 1'b0} + 10'(window[8]);
      gx_neg = 10'(window[0]) + {1'b0, window[3], 1'b0} + 10'(window[6]);
      gy_pos = 10'(window[0]) + {1'b0, window[1], 1'b0} + 10'(window[2]);
      gy_neg = 10'(window[6]) + {1'b0, window[7], 1'b0} + 10'(window[8]);
      gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
      gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
      magnitude  = 11'(gx_abs) + 11'(gy_abs);
      edge_value = (magnitude > 11'(EDGE_MAX)) ? EDGE_MAX : magnitude[PIX_W-1:0];
   end

   // Results of one pixel, in emission order: the window result, the right
   // edge of the row above, and the bottom row itself.
   always_comb begin
      slot_in[0].row    = win_stage.meta.row - ROW_W'(1);
      slot_in[0].column = win_stage.meta.column - COL_W'(1);
      slot_in[0].value  = win_stage.meta.border ? '0 : edge_value;
      slot_in[0].last   = win_stage.meta.frame_last_edge;
      slot_in[1].row    = win_stage.meta.row - ROW_W'(1);
      slot_in[1].column = win_stage.meta.last_column;
      slot_in[1].value  = '0;
      slot_in[1].last   = win_stage.meta.frame_last_above;
      slot_in[2].row    = win_stage.meta.row;
      slot_in[2].column = win_stage.meta.column;
      slot_in[2].value  = '0;
      slot_in[2].last   = win_stage.meta.frame_last_here;
      bundle_mask = {win_stage.meta.last_row,
                     win_stage.meta.row_nonzero && win_stage.meta.last_col,
                     win_stage.meta.row_nonzero && win_stage.meta.col_nonzero};
   end

   // Everything here depends on registers only, so the input side never
   // waits on rsp_tready in the same cycle.
   always_comb begin
      pending  = (mask_ff != '0);
      pop      = pending && !skid_valid_ff;
      last_one = ((mask_ff & (mask_ff - 3'd1)) == 3'd0);
      em_free  = !pending || (pop && last_one);
      advance  = !win_stage.valid || em_free;

      if (mask_ff[0]) begin
         pick = slot_ff[0];
      end else if (mask_ff[1]) begin
         pick = slot_ff[1];
      end else begin
         pick = slot_ff[2];
      end

      mask_in = mask_ff;
      if (em_free) begin
         mask_in = win_stage.valid ? bundle_mask : '0;
      end else if (pop) begin
         mask_in = mask_ff & (mask_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (em_free && win_stage.valid) begin
         slot_ff <= slot_in;
      end
   end

   // Output register plus one skid word.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_tready) begin
         out_valid_in  = skid_valid_ff || pop;
         out_in        = skid_valid_ff ? skid_ff : pick;
         skid_valid_in = 1'b0;
      end else if (pop) begin
         skid_in       = pick;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_ff.value, out_ff.column, out_ff.row});
   assign rsp_tlast  = out_ff.last;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held while the output register is empty");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.row == '0 || out_ff.column == '0)) |->
      (out_ff.value == '0))
      else $error("nonzero edge value on the top row or left column");

   a_frame_last_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last) |-> (out_ff.value == '0))
      else $error("last pixel of the frame carries a nonzero edge value");
`endif

endmodule

// ===== hdl/sobel_edge_detect_gray.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_detect_gray - streaming Sobel edge detector on gray pixels
// Path: stage 1, the window register, the result slots and the output register;
//   results for row r appear while row r+1 comes in, the last row's during it.
// Throughput: one pixel per clock while rsp_tready is high and a pixel yields at
//   most one result; results leave one per clock, so the last pixel of every row
//   below the first and bottom-row pixels after the first hold off the next pixel.
// Reset: synchronous; clears counters, window and pipeline, loads 640x480.
//   Line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sobel_edge_detect_gray #(
   parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata: blue [7:0], green [15:8], red [23:16]
   input  logic [sed_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: out_row [11:0], out_column [21:12], edge_value [29:22], zeros
   output logic [sed_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [sed_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [sed_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import sed_pkg::*;

   logic [CFG_W_W-1:0] width_ff, width_in;
   logic [CFG_H_W-1:0] height_ff, height_in;
   logic [CFG_W_W-1:0] frame_width;
   logic [CFG_H_W-1:0] frame_height;
   logic               advance;
   logic               pixel_valid;
   stage_type          win_stage;
   window_type         window;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[CFG_W_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[CFG_H_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Out-of-range sizes are saturated before use.
   always_comb begin
      if (width_ff < CFG_W_W'(MIN_SIZE)) begin
         frame_width = CFG_W_W'(MIN_SIZE);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         frame_width = CFG_W_W'(MAX_WIDTH);
      end else begin
         frame_width = width_ff;
      end

      if (height_ff < CFG_H_W'(MIN_SIZE)) begin
         frame_height = CFG_H_W'(MIN_SIZE);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         frame_height = CFG_H_W'(MAX_HEIGHT);
      end else begin
         frame_height = height_ff;
      end
   end

   assign req_tready  = advance;
   assign pixel_valid = req_tvalid && advance;

   sed_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .pixel_valid  (pixel_valid),
      .blue         (req_tdata[PIX_W-1:0]),
      .green        (req_tdata[2*PIX_W-1:PIX_W]),
      .red          (req_tdata[3*PIX_W-1:2*PIX_W]),
      .frame_width  (frame_width),
      .frame_height (frame_height),
      .win_stage    (win_stage),
      .window       (window)
   );

   sed_result u_result (
      .clock      (clock),
      .reset      (reset),
      .win_stage  (win_stage),
      .window     (window),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
